// ===== src/vfm_pkg.sv =====
// ----------------------------------------------------------------------------
// vfm_pkg
// Shared types, constants and small tables of the voxel face mesher.
// ----------------------------------------------------------------------------
package vfm_pkg;

  // default sizes
  localparam int unsigned VERTEX_CAPACITY_DEF = 4096;
  localparam int unsigned HASH_SLOTS_DEF      = 8192;
  localparam int unsigned COORD_BITS_DEF      = 12;

  // fixed field widths
  localparam int unsigned IDX_BITS  = 12;
  localparam int unsigned KIND_BITS = 2;
  localparam int unsigned NRM_BITS  = 3;
  localparam int unsigned NUM_FACES = 6;

  // multiplicative hash: product bits from HASH_SHIFT upward
  localparam logic [63:0] HASH_MULT  = 64'h9E3779B97F4A7C15;
  localparam int unsigned HASH_SHIFT = 29;

  // result kinds
  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_NORMAL   = 2'd1,
    KIND_TRIANGLE = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  // result to load into the output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_VERTEX,
    EMIT_NORMAL,
    EMIT_TRI_A,
    EMIT_TRI_B,
    EMIT_OVERFLOW
  } emit_e;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       hash_step;
    logic [1:0] hash_sel;
    logic       probe_start;
    logic       probe_next;
    logic       rd_slot;
    logic       rd_key;
    logic       alloc;
    logic       take_found;
    logic       norm_assign;
    emit_e      emit;
    logic       last;
    logic [2:0] face;
    logic [1:0] corner;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clearing;
    logic       filled;
    logic [5:0] exposed;
    logic       slot_empty;
    logic       key_hit;
    logic       key_stale;
    logic       full;
    logic       norm_assigned;
    logic       out_free;
  } sts_t;

  // cube corner of a side; bit0 +x, bit1 +y, bit2 +z
  function automatic logic [2:0] face_corner(input logic [2:0] face, input logic [1:0] k);
    logic [11:0] row;
    begin
      case (face)
        3'd0:    row = {3'd3, 3'd2, 3'd1, 3'd0};
        3'd1:    row = {3'd7, 3'd6, 3'd5, 3'd4};
        3'd2:    row = {3'd7, 3'd6, 3'd3, 3'd2};
        3'd3:    row = {3'd5, 3'd4, 3'd1, 3'd0};
        3'd4:    row = {3'd6, 3'd4, 3'd2, 3'd0};
        3'd5:    row = {3'd7, 3'd5, 3'd3, 3'd1};
        default: row = '0;
      endcase
      face_corner = row[k*3 +: 3];
    end
  endfunction

  // unit normal component of a side, axis 0 x, 1 y, 2 z
  function automatic logic signed [1:0] face_dir(input logic [2:0] face, input logic [1:0] axis);
    logic [5:0] row;
    begin
      // packed as {z, y, x}
      case (face)
        3'd0:    row = {2'b11, 2'b00, 2'b00};
        3'd1:    row = {2'b01, 2'b00, 2'b00};
        3'd2:    row = {2'b00, 2'b01, 2'b00};
        3'd3:    row = {2'b00, 2'b11, 2'b00};
        3'd4:    row = {2'b00, 2'b00, 2'b11};
        3'd5:    row = {2'b00, 2'b00, 2'b01};
        default: row = '0;
      endcase
      case (axis)
        2'd0:    face_dir = row[1:0];
        2'd1:    face_dir = row[3:2];
        2'd2:    face_dir = row[5:4];
        default: face_dir = 2'b00;
      endcase
    end
  endfunction

endpackage

// ===== src/vfm_datapath.sv =====
// ----------------------------------------------------------------------------
// vfm_datapath
// Voxel registers, corner hash, vertex hash and key memories, normal table
// and the output register.
// ----------------------------------------------------------------------------
module vfm_datapath #(
  parameter int unsigned VERTEX_CAPACITY = vfm_pkg::VERTEX_CAPACITY_DEF,
  parameter int unsigned HASH_SLOTS      = vfm_pkg::HASH_SLOTS_DEF,
  parameter int unsigned COORD_BITS      = vfm_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vfm_pkg::cmd_t                  cmd_i,
  output vfm_pkg::sts_t                  sts_o,
  input  logic                           new_mesh_i,
  input  logic signed [COORD_BITS-1:0]   voxel_x_i,
  input  logic signed [COORD_BITS-1:0]   voxel_y_i,
  input  logic signed [COORD_BITS-1:0]   voxel_z_i,
  input  logic                           filled_self_i,
  input  logic                           filled_below_i,
  input  logic                           filled_above_i,
  input  logic                           filled_front_i,
  input  logic                           filled_behind_i,
  input  logic                           filled_left_i,
  input  logic                           filled_right_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic [vfm_pkg::IDX_BITS-1:0]   entry_index_o,
  output logic signed [COORD_BITS:0]     coord_x_o,
  output logic signed [COORD_BITS:0]     coord_y_o,
  output logic signed [COORD_BITS:0]     coord_z_o,
  output logic [vfm_pkg::IDX_BITS-1:0]   tri_first_o,
  output logic [vfm_pkg::IDX_BITS-1:0]   tri_second_o,
  output logic [vfm_pkg::IDX_BITS-1:0]   tri_third_o,
  output logic [vfm_pkg::NRM_BITS-1:0]   tri_normal_o,
  output logic                           last_o
);

  localparam int unsigned CBITS = COORD_BITS + 1;
  localparam int unsigned HBITS = $clog2(HASH_SLOTS);
  localparam int unsigned CLRW  = HBITS + 1;
  localparam int unsigned HB    = vfm_pkg::HASH_SHIFT + HBITS;
  localparam int unsigned SW    = $clog2(VERTEX_CAPACITY + 1);
  localparam int unsigned IW    = $clog2(VERTEX_CAPACITY);
  localparam int unsigned KEYW  = 3 * CBITS;
  localparam int unsigned KW    = KEYW + HBITS;
  localparam logic [HB-1:0] MULT0 = HB'(vfm_pkg::HASH_MULT);
  localparam logic [HB-1:0] MULT1 = HB'(vfm_pkg::HASH_MULT << CBITS);
  localparam logic [HB-1:0] MULT2 = HB'(vfm_pkg::HASH_MULT << (2 * CBITS));

  // voxel registers
  logic [COORD_BITS-1:0] vx_q, vy_q, vz_q;
  logic                  filled_q;
  logic [5:0]            exposed_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vx_q      <= voxel_x_i;
      vy_q      <= voxel_y_i;
      vz_q      <= voxel_z_i;
      filled_q  <= filled_self_i;
      exposed_q <= ~{filled_right_i, filled_left_i, filled_behind_i,
                     filled_front_i, filled_above_i, filled_below_i};
    end
  end

  // corner point of the current side and corner
  logic [2:0]       corner;
  logic [CBITS-1:0] px, py, pz;
  logic [KEYW-1:0]  key;

  assign corner = vfm_pkg::face_corner(cmd_i.face, cmd_i.corner);
  assign px  = {vx_q[COORD_BITS-1], vx_q} + CBITS'(corner[0]);
  assign py  = {vy_q[COORD_BITS-1], vy_q} + CBITS'(corner[1]);
  assign pz  = {vz_q[COORD_BITS-1], vz_q} + CBITS'(corner[2]);
  assign key = {pz, py, px};

  // hash, one coordinate chunk per cycle
  logic [HB-1:0]    acc_q, acc_d, mult, chunk_ext;
  logic [CBITS-1:0] chunk;

  always_comb begin
    case (cmd_i.hash_sel)
      2'd0:    begin chunk = px; mult = MULT0; end
      2'd1:    begin chunk = py; mult = MULT1; end
      2'd2:    begin chunk = pz; mult = MULT2; end
      default: begin chunk = '0; mult = '0;    end
    endcase
    chunk_ext = HB'(chunk);
    acc_d = ((cmd_i.hash_sel == 2'd0) ? '0 : acc_q) + chunk_ext * mult;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_step) acc_q <= acc_d;
  end

  // probe slot pointer
  logic [HBITS-1:0] h_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_start)     h_q <= acc_q[vfm_pkg::HASH_SHIFT +: HBITS];
    else if (cmd_i.probe_next) h_q <= h_q + HBITS'(1);
  end

  // clearing pass over the hash slots after reset
  logic [CLRW-1:0] clr_q;
  logic            clearing;

  assign clearing = !clr_q[HBITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + CLRW'(1);
    end
  end

  // vertex count and tables
  logic [SW-1:0]  count_q;
  logic [SW-1:0]  slot_rd_q, slot_m1;
  logic [KW-1:0]  key_rd_q;
  logic [SW-1:0]  slot_mem [HASH_SLOTS];
  logic [KW-1:0]  key_mem  [VERTEX_CAPACITY];

  assign slot_m1 = slot_rd_q - SW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load && new_mesh_i) begin
      count_q <= '0;
    end else if (cmd_i.alloc) begin
      count_q <= count_q + SW'(1);
    end
  end

  // hash slot memory: slot holds vertex index plus one
  always_ff @(posedge clk_i) begin
    if (clearing)         slot_mem[clr_q[HBITS-1:0]] <= '0;
    else if (cmd_i.alloc) slot_mem[h_q] <= count_q + SW'(1);
    if (cmd_i.rd_slot) slot_rd_q <= slot_mem[h_q];
  end

  // key memory: entry also records the slot that owns it
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) key_mem[count_q[IW-1:0]] <= {h_q, key};
    if (cmd_i.rd_key) key_rd_q <= key_mem[slot_m1[IW-1:0]];
  end

  // corner indices of the current side
  logic [IW-1:0] vi_q [4];

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc)           vi_q[cmd_i.corner] <= count_q[IW-1:0];
    else if (cmd_i.take_found) vi_q[cmd_i.corner] <= slot_m1[IW-1:0];
  end

  // normal table
  logic [5:0] nvalid_q;
  logic [2:0] nslot_q [6];
  logic [2:0] ncount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvalid_q <= '0;
      ncount_q <= '0;
    end else if (cmd_i.load && new_mesh_i) begin
      nvalid_q <= '0;
      ncount_q <= '0;
    end else if (cmd_i.norm_assign) begin
      nvalid_q[cmd_i.face] <= 1'b1;
      ncount_q             <= ncount_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_assign) nslot_q[cmd_i.face] <= ncount_q;
  end

  // status
  logic out_valid_q;

  assign sts_o.clearing      = clearing;
  assign sts_o.filled        = filled_q;
  assign sts_o.exposed       = exposed_q;
  assign sts_o.slot_empty    = (slot_rd_q == '0) || (slot_rd_q > count_q);
  assign sts_o.key_stale     = key_rd_q[KW-1 -: HBITS] != h_q;
  assign sts_o.key_hit       = !sts_o.key_stale && (key_rd_q[KEYW-1:0] == key);
  assign sts_o.full          = count_q >= SW'(VERTEX_CAPACITY);
  assign sts_o.norm_assigned = nvalid_q[cmd_i.face];
  assign sts_o.out_free      = !out_valid_q || out_ready_i;

  // index to the 12-bit result field
  function automatic logic [vfm_pkg::IDX_BITS-1:0] to_idx(input logic [IW-1:0] v);
    logic [31:0] w;
    begin
      w      = 32'(v);
      to_idx = w[vfm_pkg::IDX_BITS-1:0];
    end
  endfunction

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit != vfm_pkg::EMIT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != vfm_pkg::EMIT_NONE) begin
      entry_index_o <= '0;
      coord_x_o     <= '0;
      coord_y_o     <= '0;
      coord_z_o     <= '0;
      tri_first_o   <= '0;
      tri_second_o  <= '0;
      tri_third_o   <= '0;
      tri_normal_o  <= '0;
      last_o        <= cmd_i.last;
      case (cmd_i.emit)
        vfm_pkg::EMIT_VERTEX: begin
          kind_o        <= vfm_pkg::KIND_VERTEX;
          entry_index_o <= to_idx(count_q[IW-1:0] - IW'(1));
          coord_x_o     <= px;
          coord_y_o     <= py;
          coord_z_o     <= pz;
        end
        vfm_pkg::EMIT_NORMAL: begin
          kind_o        <= vfm_pkg::KIND_NORMAL;
          entry_index_o <= vfm_pkg::IDX_BITS'(ncount_q);
          coord_x_o     <= CBITS'(vfm_pkg::face_dir(cmd_i.face, 2'd0));
          coord_y_o     <= CBITS'(vfm_pkg::face_dir(cmd_i.face, 2'd1));
          coord_z_o     <= CBITS'(vfm_pkg::face_dir(cmd_i.face, 2'd2));
        end
        vfm_pkg::EMIT_TRI_A: begin
          kind_o       <= vfm_pkg::KIND_TRIANGLE;
          tri_first_o  <= to_idx(vi_q[0]);
          tri_second_o <= to_idx(vi_q[1]);
          tri_third_o  <= to_idx(vi_q[2]);
          tri_normal_o <= nslot_q[cmd_i.face];
        end
        vfm_pkg::EMIT_TRI_B: begin
          kind_o       <= vfm_pkg::KIND_TRIANGLE;
          tri_first_o  <= to_idx(vi_q[1]);
          tri_second_o <= to_idx(vi_q[2]);
          tri_third_o  <= to_idx(vi_q[3]);
          tri_normal_o <= nslot_q[cmd_i.face];
        end
        default: begin
          kind_o <= vfm_pkg::KIND_OVERFLOW;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SW'(VERTEX_CAPACITY)) else $error("vertex count past capacity");
  a_ncount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncount_q <= 3'd6) else $error("normal count past six");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit != vfm_pkg::EMIT_NONE) |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a waiting item");
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit == vfm_pkg::EMIT_OVERFLOW) |=> last_o)
    else $error("overflow result not marked last");

endmodule

// ===== src/vfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// vfm_ctrl
// Sequencer over sides, corners, hash probes and result slots.
// ----------------------------------------------------------------------------
module vfm_ctrl #(
  parameter int unsigned HASH_SLOTS = vfm_pkg::HASH_SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vfm_pkg::sts_t sts_i,
  output vfm_pkg::cmd_t cmd_o
);

  localparam int unsigned PW = $clog2(HASH_SLOTS) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_FACE, S_HASH, S_HSEL, S_RDSLOT, S_CHKSLOT, S_CHKKEY,
    S_EMITV, S_NORM, S_NEXT, S_TRI_A, S_TRI_B, S_OVF
  } state_e;

  state_e        state_q, state_d;
  logic [2:0]    face_q, face_d;
  logic [1:0]    corner_q, corner_d;
  logic [1:0]    hsel_q, hsel_d;
  logic [PW-1:0] probe_q, probe_d;
  logic          later;

  // any exposed side after the current one
  always_comb begin
    later = 1'b0;
    for (int i = 0; i < vfm_pkg::NUM_FACES; i++) begin
      if (sts_i.exposed[i] && (3'(i) > face_q)) later = 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    face_d   = face_q;
    corner_d = corner_q;
    hsel_d   = hsel_q;
    probe_d  = probe_q;
    cmd_o    = '0;
    cmd_o.emit     = vfm_pkg::EMIT_NONE;
    cmd_o.face     = face_q;
    cmd_o.corner   = corner_q;
    cmd_o.hash_sel = hsel_q;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = !sts_i.clearing;
        if (in_valid_i && !sts_i.clearing) begin
          cmd_o.load = 1'b1;
          face_d     = '0;
          state_d    = S_FACE;
        end
      end
      S_FACE: begin
        if (!sts_i.filled || face_q == 3'd6) begin
          state_d = S_IDLE;
        end else if (sts_i.exposed[face_q]) begin
          corner_d = '0;
          hsel_d   = '0;
          state_d  = S_HASH;
        end else begin
          face_d = face_q + 3'd1;
        end
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        hsel_d = hsel_q + 2'd1;
        if (hsel_q == 2'd2) state_d = S_HSEL;
      end
      S_HSEL: begin
        cmd_o.probe_start = 1'b1;
        probe_d = '0;
        state_d = S_RDSLOT;
      end
      S_RDSLOT: begin
        cmd_o.rd_slot = 1'b1;
        state_d = S_CHKSLOT;
      end
      S_CHKSLOT: begin
        if (sts_i.slot_empty) begin
          if (sts_i.full) begin
            state_d = S_OVF;
          end else begin
            cmd_o.alloc = 1'b1;
            state_d = S_EMITV;
          end
        end else begin
          cmd_o.rd_key = 1'b1;
          state_d = S_CHKKEY;
        end
      end
      S_CHKKEY: begin
        if (sts_i.key_stale) begin
          if (sts_i.full) begin
            state_d = S_OVF;
          end else begin
            cmd_o.alloc = 1'b1;
            state_d = S_EMITV;
          end
        end else if (sts_i.key_hit) begin
          cmd_o.take_found = 1'b1;
          state_d = (corner_q == 2'd0) ? S_NORM : S_NEXT;
        end else if (probe_q == PW'(HASH_SLOTS - 1)) begin
          state_d = S_OVF;
        end else begin
          cmd_o.probe_next = 1'b1;
          probe_d = probe_q + PW'(1);
          state_d = S_RDSLOT;
        end
      end
      S_EMITV: begin
        if (sts_i.out_free) begin
          cmd_o.emit = vfm_pkg::EMIT_VERTEX;
          state_d = (corner_q == 2'd0) ? S_NORM : S_NEXT;
        end
      end
      S_NORM: begin
        if (sts_i.norm_assigned) begin
          state_d = S_NEXT;
        end else if (sts_i.out_free) begin
          cmd_o.emit        = vfm_pkg::EMIT_NORMAL;
          cmd_o.norm_assign = 1'b1;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (corner_q == 2'd3) begin
          state_d = S_TRI_A;
        end else begin
          corner_d = corner_q + 2'd1;
          hsel_d   = '0;
          state_d  = S_HASH;
        end
      end
      S_TRI_A: begin
        if (sts_i.out_free) begin
          cmd_o.emit = vfm_pkg::EMIT_TRI_A;
          state_d = S_TRI_B;
        end
      end
      S_TRI_B: begin
        if (sts_i.out_free) begin
          cmd_o.emit = vfm_pkg::EMIT_TRI_B;
          cmd_o.last = !later;
          face_d  = face_q + 3'd1;
          state_d = later ? S_FACE : S_IDLE;
        end
      end
      S_OVF: begin
        if (sts_i.out_free) begin
          cmd_o.emit = vfm_pkg::EMIT_OVERFLOW;
          cmd_o.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      face_q   <= '0;
      corner_q <= '0;
      hsel_q   <= '0;
      probe_q  <= '0;
    end else begin
      state_q  <= state_d;
      face_q   <= face_d;
      corner_q <= corner_d;
      hsel_q   <= hsel_d;
      probe_q  <= probe_d;
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE)) else $error("ready outside idle");
  a_hash_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HSEL) |-> $past(state_q == S_HASH) && (hsel_q == 2'd3))
    else $error("hash not run over three chunks");
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HASH) |-> (face_q < 3'd6)) else $error("corner lookup past last side");

endmodule

// ===== src/voxel_face_mesher.sv =====
// ----------------------------------------------------------------------------
// voxel_face_mesher
// Culls hidden sides of a voxel and emits deduplicated vertices, normals and
// the two triangles of each exposed side, or overflow when slots run out.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid_i/in_ready_o  new_mesh, voxel_x/y/z, filled_* (one voxel)
//  out      out_valid_o/out_ready_i kind, entry_index, coord_*, tri_*, last
//
//  One voxel at a time: the sequencer takes it and checks each side in turn;
//  per exposed side it runs four corner lookups, each hashing the three
//  coordinate chunks and reading a hash slot and then its key entry, plus a
//  further probe per collision, then the normal check and the results.
//  After reset a clearing pass empties the hash slots with in_ready_o low;
//  counts and normal table clear at once.
//  A stalled output holds the sequencer at the next result; a voxel is taken
//  while the last result of the previous one still waits.
// ----------------------------------------------------------------------------
module voxel_face_mesher #(
  parameter int unsigned VERTEX_CAPACITY = vfm_pkg::VERTEX_CAPACITY_DEF,
  parameter int unsigned HASH_SLOTS      = vfm_pkg::HASH_SLOTS_DEF,
  parameter int unsigned COORD_BITS      = vfm_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           new_mesh_i,
  input  logic signed [COORD_BITS-1:0]   voxel_x_i,
  input  logic signed [COORD_BITS-1:0]   voxel_y_i,
  input  logic signed [COORD_BITS-1:0]   voxel_z_i,
  input  logic                           filled_self_i,
  input  logic                           filled_below_i,
  input  logic                           filled_above_i,
  input  logic                           filled_front_i,
  input  logic                           filled_behind_i,
  input  logic                           filled_left_i,
  input  logic                           filled_right_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic [vfm_pkg::IDX_BITS-1:0]   entry_index_o,
  output logic signed [COORD_BITS:0]     coord_x_o,
  output logic signed [COORD_BITS:0]     coord_y_o,
  output logic signed [COORD_BITS:0]     coord_z_o,
  output logic [vfm_pkg::IDX_BITS-1:0]   tri_first_o,
  output logic [vfm_pkg::IDX_BITS-1:0]   tri_second_o,
  output logic [vfm_pkg::IDX_BITS-1:0]   tri_third_o,
  output logic [vfm_pkg::NRM_BITS-1:0]   tri_normal_o,
  output logic                           last_o
);

  vfm_pkg::cmd_t cmd;
  vfm_pkg::sts_t sts;

  // sequencer
  vfm_ctrl #(
    .HASH_SLOTS(HASH_SLOTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tables and result path
  vfm_datapath #(
    .VERTEX_CAPACITY(VERTEX_CAPACITY),
    .HASH_SLOTS     (HASH_SLOTS),
    .COORD_BITS     (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .new_mesh_i      (new_mesh_i),
    .voxel_x_i       (voxel_x_i),
    .voxel_y_i       (voxel_y_i),
    .voxel_z_i       (voxel_z_i),
    .filled_self_i   (filled_self_i),
    .filled_below_i  (filled_below_i),
    .filled_above_i  (filled_above_i),
    .filled_front_i  (filled_front_i),
    .filled_behind_i (filled_behind_i),
    .filled_left_i   (filled_left_i),
    .filled_right_i  (filled_right_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .entry_index_o   (entry_index_o),
    .coord_x_o       (coord_x_o),
    .coord_y_o       (coord_y_o),
    .coord_z_o       (coord_z_o),
    .tri_first_o     (tri_first_o),
    .tri_second_o    (tri_second_o),
    .tri_third_o     (tri_third_o),
    .tri_normal_o    (tri_normal_o),
    .last_o          (last_o)
  );

endmodule
